[hw/rtl/spch_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spch_pkg: shared types and constants for the polygon convex hull unit
// Widths, deque sizing, status codes, FSM states and controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package spch_pkg;

    localparam int COORD_W     = 16;
    localparam int DEQUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(DEQUE_DEPTH);
    localparam int CNT_W       = $clog2(DEQUE_DEPTH + 1);
    localparam int VTX_W       = 2 * COORD_W;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int TDATA_W     = ((VTX_W + 7) / 8) * 8;
    localparam int TUSER_W     = 2;
    localparam int MIN_HULL    = 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vertex_t;

    // STS_VERTEX doubles as "no error" in the error register
    typedef enum logic [1:0] {
        STS_VERTEX    = 2'd0,
        STS_FEW       = 2'd1,
        STS_UNDERFLOW = 2'd2,
        STS_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RD,
        ST_MUL,
        ST_EVAL,
        ST_BUILD1,
        ST_BUILD2,
        ST_BUILD3,
        ST_FINAL,
        ST_STATUS,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef enum logic [2:0] {
        OP_BUILD,
        OP_INBOT,
        OP_INTOP,
        OP_POPTOP,
        OP_REMBOT
    } cross_op_t;

    // operand set of the cross product unit
    typedef enum logic [1:0] {
        XS_BUILD,
        XS_TOP,
        XS_BOT
    } xsel_t;

    typedef enum logic [1:0] {
        WS_FIRST,
        WS_SECOND,
        WS_POINT
    } wsel_t;

    typedef struct packed {
        logic    capture;
        logic    store_first;
        logic    store_second;
        logic    set_seen3;
        logic    rd_en;
        logic    rd_emit;
        xsel_t   xsel;
        logic    mul_en;
        logic    push;
        logic    ins;
        wsel_t   wsel;
        logic    pop;
        logic    rem;
        logic    set_err;
        status_t err_code;
        logic    out_vertex;
        logic    out_status;
        logic    k_inc;
        logic    clear;
    } dp_cmd_t;

    typedef struct packed {
        logic       x_pos;
        logic       x_neg;
        logic       count_le3;
        logic       full;
        logic       err_any;
        logic [1:0] seen;
        logic       final_flag;
        logic       out_free;
        logic       emit_last;
    } dp_status_t;

    function automatic xsel_t xsel_of(input cross_op_t op);
        xsel_t s;
        case (op)
            OP_BUILD:  s = XS_BUILD;
            OP_INTOP:  s = XS_TOP;
            OP_POPTOP: s = XS_TOP;
            OP_INBOT:  s = XS_BOT;
            OP_REMBOT: s = XS_BOT;
            default:   s = XS_BOT;
        endcase
        return s;
    endfunction

    // circular deque slot: (base + off) mod DEQUE_DEPTH, off <= DEQUE_DEPTH
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEQUE_DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEQUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

[hw/rtl/spch_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spch_ctrl: sequencing FSM of the convex hull unit
// Walks each vertex through the cross product unit, runs the pop/remove
// loops, and drives result emission.
// ----------------------------------------------------------------------------
module spch_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  spch_pkg::dp_status_t sts,
    output spch_pkg::dp_cmd_t    cmd
);
    import spch_pkg::*;

    state_t    state_reg, state_next;
    cross_op_t op_reg, op_next;
    logic      bot_ok_reg, bot_ok_next;
    logic      pos_reg, pos_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_BUILD;
            bot_ok_reg <= 1'b0;
            pos_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            bot_ok_reg <= bot_ok_next;
            pos_reg    <= pos_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        bot_ok_next = bot_ok_reg;
        pos_next    = pos_reg;
        cmd         = '0;
        s_tready    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end

            ST_DISPATCH: begin
                if (sts.err_any) begin
                    state_next = ST_FINAL;
                end else begin
                    case (sts.seen)
                        2'd0: begin
                            cmd.store_first = 1'b1;
                            state_next      = ST_FINAL;
                        end
                        2'd1: begin
                            cmd.store_second = 1'b1;
                            state_next       = ST_FINAL;
                        end
                        2'd2: begin
                            op_next    = OP_BUILD;
                            state_next = ST_RD;
                        end
                        default: begin
                            op_next    = OP_INBOT;
                            state_next = ST_RD;
                        end
                    endcase
                end
            end

            ST_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.xsel   = xsel_of(op_reg);
                state_next = ST_MUL;
            end

            ST_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.xsel   = xsel_of(op_reg);
                state_next = ST_EVAL;
            end

            ST_EVAL: begin
                case (op_reg)
                    OP_BUILD: begin
                        // counter-clockwise start: first, second, point, or second, first, point if not a left turn
                        cmd.push   = 1'b1;
                        cmd.wsel   = sts.x_pos ? WS_FIRST : WS_SECOND;
                        pos_next   = sts.x_pos;
                        state_next = ST_BUILD1;
                    end
                    OP_INBOT: begin
                        bot_ok_next = !sts.x_neg;
                        op_next     = OP_INTOP;
                        state_next  = ST_RD;
                    end
                    OP_INTOP, OP_POPTOP: begin
                        if (op_reg == OP_INTOP && bot_ok_reg && !sts.x_neg) begin
                            // inside the current hull
                            state_next = ST_FINAL;
                        end else if (!sts.x_pos) begin
                            if (sts.count_le3) begin
                                cmd.set_err  = 1'b1;
                                cmd.err_code = STS_UNDERFLOW;
                                state_next   = ST_FINAL;
                            end else begin
                                cmd.pop    = 1'b1;
                                op_next    = OP_POPTOP;
                                state_next = ST_RD;
                            end
                        end else if (sts.full) begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = STS_OVERFLOW;
                            state_next   = ST_FINAL;
                        end else begin
                            cmd.push   = 1'b1;
                            cmd.wsel   = WS_POINT;
                            op_next    = OP_REMBOT;
                            state_next = ST_RD;
                        end
                    end
                    OP_REMBOT: begin
                        if (!sts.x_pos) begin
                            if (sts.count_le3) begin
                                cmd.set_err  = 1'b1;
                                cmd.err_code = STS_UNDERFLOW;
                                state_next   = ST_FINAL;
                            end else begin
                                cmd.rem    = 1'b1;
                                state_next = ST_RD;
                            end
                        end else if (sts.full) begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = STS_OVERFLOW;
                            state_next   = ST_FINAL;
                        end else begin
                            cmd.ins    = 1'b1;
                            cmd.wsel   = WS_POINT;
                            state_next = ST_FINAL;
                        end
                    end
                    default: begin
                        state_next = ST_FINAL;
                    end
                endcase
            end

            ST_BUILD1: begin
                cmd.push   = 1'b1;
                cmd.wsel   = pos_reg ? WS_SECOND : WS_FIRST;
                state_next = ST_BUILD2;
            end

            ST_BUILD2: begin
                cmd.push   = 1'b1;
                cmd.wsel   = WS_POINT;
                state_next = ST_BUILD3;
            end

            ST_BUILD3: begin
                cmd.ins       = 1'b1;
                cmd.wsel      = WS_POINT;
                cmd.set_seen3 = 1'b1;
                state_next    = ST_FINAL;
            end

            ST_FINAL: begin
                if (!sts.final_flag) begin
                    state_next = ST_IDLE;
                end else if (sts.err_any || sts.seen != 2'd3) begin
                    state_next = ST_STATUS;
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end

            ST_STATUS: begin
                if (sts.out_free) begin
                    cmd.out_status = 1'b1;
                    cmd.clear      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_EMIT_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_emit = 1'b1;
                state_next  = ST_EMIT_LD;
            end

            ST_EMIT_LD: begin
                if (sts.out_free) begin
                    cmd.out_vertex = 1'b1;
                    if (sts.emit_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.k_inc  = 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/spch_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spch_datapath: deque storage, cross product unit and output register
// Holds the circular hull deque, the pointers and counters, a two-stage
// cross product (multiply, then subtract/compare) and the result register.
// ----------------------------------------------------------------------------
module spch_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  spch_pkg::dp_cmd_t                 cmd,
    output spch_pkg::dp_status_t              sts,
    // s_tdata: point_x, point_y
    input  logic [spch_pkg::TDATA_W-1:0]      s_tdata,
    input  logic                              s_tlast,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    // m_tdata: hull_x, hull_y
    output logic [spch_pkg::TDATA_W-1:0]      m_tdata,
    output logic                              m_tlast,
    // m_tuser: status
    output logic [spch_pkg::TUSER_W-1:0]      m_tuser
);
    import spch_pkg::*;

    logic [VTX_W-1:0] mem [DEQUE_DEPTH];

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [1:0]       seen_reg, seen_next;
    status_t          err_reg, err_next;
    logic             out_valid_reg, out_valid_next;

    vertex_t          pt_reg, first_reg, second_reg;
    logic             final_reg;
    vertex_t          rd_a_reg, rd_b_reg;
    logic signed [PROD_W-1:0] prod1_reg, prod2_reg;
    vertex_t          out_vtx_reg;
    logic             out_last_reg;
    status_t          out_sts_reg;

    logic [IDX_W-1:0] addr_a, addr_b, wr_addr;
    logic [IDX_W-1:0] front_inc, front_dec;
    logic             wr_en;
    vertex_t          wr_data;
    vertex_t          op_a, op_b, op_c;
    logic signed [DIFF_W-1:0]  dx1, dy1, dx2, dy2;
    logic signed [CROSS_W-1:0] cross_val;
    logic             out_free;

    assign front_inc = (front_reg == IDX_W'(DEQUE_DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? IDX_W'(DEQUE_DEPTH - 1) : front_reg - 1'b1;

    // read addresses
    always_comb begin
        if (cmd.rd_emit) begin
            addr_a = slot_of(front_reg, k_reg);
            addr_b = slot_of(front_reg, k_reg);
        end else begin
            case (cmd.xsel)
                XS_TOP: begin
                    addr_a = slot_of(front_reg, count_reg - CNT_W'(2));
                    addr_b = slot_of(front_reg, count_reg - CNT_W'(1));
                end
                default: begin
                    addr_a = front_reg;
                    addr_b = slot_of(front_reg, CNT_W'(1));
                end
            endcase
        end
    end

    // write port
    always_comb begin
        wr_en   = cmd.push || cmd.ins;
        wr_addr = cmd.push ? slot_of(front_reg, count_reg) : front_dec;
        case (cmd.wsel)
            WS_FIRST:  wr_data = first_reg;
            WS_SECOND: wr_data = second_reg;
            default:   wr_data = pt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
    end

    // cross(a, b, c) = (b - a) x (c - a)
    always_comb begin
        case (cmd.xsel)
            XS_BUILD: begin
                op_a = first_reg;
                op_b = second_reg;
                op_c = pt_reg;
            end
            XS_TOP: begin
                op_a = rd_a_reg;
                op_b = rd_b_reg;
                op_c = pt_reg;
            end
            default: begin
                op_a = pt_reg;
                op_b = rd_a_reg;
                op_c = rd_b_reg;
            end
        endcase
        dx1 = $signed({op_b.x[COORD_W-1], op_b.x}) - $signed({op_a.x[COORD_W-1], op_a.x});
        dy1 = $signed({op_b.y[COORD_W-1], op_b.y}) - $signed({op_a.y[COORD_W-1], op_a.y});
        dx2 = $signed({op_c.x[COORD_W-1], op_c.x}) - $signed({op_a.x[COORD_W-1], op_a.x});
        dy2 = $signed({op_c.y[COORD_W-1], op_c.y}) - $signed({op_a.y[COORD_W-1], op_a.y});
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod1_reg <= dx1 * dy2;
            prod2_reg <= dy1 * dx2;
        end
    end

    assign cross_val = $signed({prod1_reg[PROD_W-1], prod1_reg})
                     - $signed({prod2_reg[PROD_W-1], prod2_reg});

    // payload captures
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pt_reg.x  <= s_tdata[COORD_W-1:0];
            pt_reg.y  <= s_tdata[VTX_W-1:COORD_W];
            final_reg <= s_tlast;
        end
        if (cmd.store_first) begin
            first_reg <= pt_reg;
        end
        if (cmd.store_second) begin
            second_reg <= pt_reg;
        end
    end

    // pointers, counters, error
    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        k_next     = k_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;

        if (cmd.push) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.ins) begin
            front_next = front_dec;
            count_next = count_reg + 1'b1;
        end else if (cmd.pop) begin
            count_next = count_reg - 1'b1;
        end else if (cmd.rem) begin
            front_next = front_inc;
            count_next = count_reg - 1'b1;
        end

        if (cmd.store_first) begin
            seen_next = 2'd1;
        end else if (cmd.store_second) begin
            seen_next = 2'd2;
        end else if (cmd.set_seen3) begin
            seen_next = 2'd3;
        end

        if (cmd.set_err) begin
            err_next = cmd.err_code;
        end
        if (cmd.k_inc) begin
            k_next = k_reg + 1'b1;
        end

        // polygon done: back to the empty state
        if (cmd.clear) begin
            front_next = '0;
            count_next = '0;
            k_next     = '0;
            seen_next  = '0;
            err_next   = STS_VERTEX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            seen_reg      <= '0;
            err_reg       <= STS_VERTEX;
            out_valid_reg <= 1'b0;
        end else begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            seen_reg      <= seen_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_vertex || cmd.out_status) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_vertex) begin
            out_vtx_reg  <= rd_a_reg;
            out_last_reg <= sts.emit_last;
            out_sts_reg  <= STS_VERTEX;
        end else if (cmd.out_status) begin
            out_vtx_reg  <= '0;
            out_last_reg <= 1'b1;
            out_sts_reg  <= (err_reg != STS_VERTEX) ? err_reg : STS_FEW;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({out_vtx_reg.y, out_vtx_reg.x});
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_sts_reg;

    always_comb begin
        sts            = '0;
        sts.x_neg      = cross_val[CROSS_W-1];
        sts.x_pos      = !cross_val[CROSS_W-1] && (cross_val != '0);
        sts.count_le3  = (count_reg <= CNT_W'(MIN_HULL));
        sts.full       = (count_reg >= CNT_W'(DEQUE_DEPTH));
        sts.err_any    = (err_reg != STS_VERTEX);
        sts.seen       = seen_reg;
        sts.final_flag = final_reg;
        sts.out_free   = out_free;
        sts.emit_last  = ((k_reg + 1'b1) == count_reg);
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEQUE_DEPTH))
        else $error("deque count above depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push || cmd.ins) |-> (count_reg < CNT_W'(DEQUE_DEPTH)))
        else $error("write into a full deque");

    a_no_pop_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop || cmd.rem) |-> (count_reg > CNT_W'(MIN_HULL)))
        else $error("pop or removal below three entries");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_vertex || cmd.out_status) |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before transaction");
`endif

endmodule

[hw/rtl/simple_polygon_convex_hull_unit.sv]
`timescale 1ns / 1ps
// Processing: the first two vertices are only stored; the third builds the start hull; later
//   vertices may pop top or remove bottom entries, all tested by one shared cross product.
// Output: each hull vertex is read from the deque memory read port; a status item needs no read.
// One vertex in flight at a time; s_tready is high only between vertices.
// Reset: aresetn synchronous active low clears FSM, pointers, counters and flags;
//   deque memory is not cleared.
// ----------------------------------------------------------------------------
// simple_polygon_convex_hull_unit: streaming Melkman convex hull
// Takes polygon vertices one per transaction, emits the hull (front to back,
// end vertex repeated) or one status item on the last vertex.
// ----------------------------------------------------------------------------
module simple_polygon_convex_hull_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: point_x [15:0], point_y [31:16]
    input  logic [spch_pkg::TDATA_W-1:0]      s_tdata,
    // s_tlast: final_point
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: hull_x [15:0], hull_y [31:16]
    output logic [spch_pkg::TDATA_W-1:0]      m_tdata,
    // m_tlast: end_of_hull
    output logic                              m_tlast,
    // m_tuser: status [1:0]
    output logic [spch_pkg::TUSER_W-1:0]      m_tuser
);
    import spch_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    spch_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spch_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
